// ===== rtl/vpp_pkg.sv =====
package vpp_pkg;

    localparam int PAGE_ROWS   = 8;
    localparam int SUB_W       = $clog2(PAGE_ROWS);
    localparam int PIXEL_W     = 8;
    localparam int BYTE_W      = 8;
    localparam int COL_W       = 8;
    localparam int ROW_W       = 8;
    localparam int PAGE_W      = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int OUT_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [COL_W-1:0] WIDTH_RESET  = 8'd128;
    localparam logic [ROW_W-1:0] HEIGHT_RESET = 8'd64;

    // position of one pixel in the raster, with its end-of-row/image flags
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last_col;
        logic             last_row;
    } pix_pos_t;

endpackage

// ===== rtl/vpp_ctrl.sv =====
module vpp_ctrl
    import vpp_pkg::*;
#(
    parameter int MAX_WIDTH = 256,
    parameter int AW        = $clog2(MAX_WIDTH)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   advance,
    output pix_pos_t               pos,
    output logic [AW-1:0]          slot
);

    localparam logic [AW-1:0] SLOT_MAX = AW'(MAX_WIDTH - 1);

    logic [COL_W-1:0] width_reg;
    logic [ROW_W-1:0] height_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [AW-1:0]    slot_reg;
    logic [AW-1:0]    slot_next;
    logic             last_col;
    logic             last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // a count at or past the bound counts as the last one
    assign last_col = ({1'b0, col_reg} + 9'd1) >= {1'b0, width_reg};
    assign last_row = ({1'b0, row_reg} + 9'd1) >= {1'b0, height_reg};

    always_comb
    begin
        col_next  = col_reg + 8'd1;
        row_next  = row_reg;
        slot_next = (slot_reg == SLOT_MAX) ? '0 : slot_reg + AW'(1);
        if (last_col)
        begin
            col_next  = '0;
            slot_next = '0;
            row_next  = last_row ? '0 : row_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (advance)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    assign pos.col      = col_reg;
    assign pos.row      = row_reg;
    assign pos.last_col = last_col;
    assign pos.last_row = last_row;
    assign slot         = slot_reg;

endmodule

// ===== rtl/vpp_colbuf.sv =====
module vpp_colbuf
    import vpp_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem_reg [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [BYTE_W-1:0] fwd_data_reg;
    logic              fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // a write to the same column in the read cycle wins over the old entry
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= mem_reg[rd_addr];
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

// ===== rtl/bitmap_vertical_page_packer.sv =====
// Packs greyscale raster pixels (one s_tdata word per pixel, row-major) into
// vertical page bytes for monochrome displays: each output word carries the
// eight pixels of one column in one page, bit 0 the top row. A word leaves
// when the page's last row or the image's last row passes that column; the
// image's final word has m_tlast set. One pixel is accepted per clock when
// the output side keeps up. A pixel is first registered with the registered
// read of the column buffer (MAX_WIDTH bytes, one read and one write port),
// and the merged byte is then captured in the output register. Same-column
// writes in the read cycle are forwarded, so any width from 1 up runs at full
// rate. Write image_width and image_height only while the block is idle,
// ideally between images.
module bitmap_vertical_page_packer
    import vpp_pkg::*;
#(
    parameter int MAX_WIDTH = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PIXEL_W-1:0]     s_tdata,    // [7:0] pixel_value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,    // [7:0] page_byte, [15:8] column_index,
                                               // [20:16] page_index, [23:21] zero
    output logic                   m_tlast,    // image_done
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    pix_pos_t          pos;
    logic [AW-1:0]     slot;
    logic              accept;
    logic [BYTE_W-1:0] rd_data;

    logic              s1_valid_reg;
    logic              s1_lit_reg;
    pix_pos_t          s1_pos_reg;
    logic [AW-1:0]     s1_slot_reg;

    logic [SUB_W-1:0]  s1_sub;
    logic [BYTE_W-1:0] s1_bit;
    logic [BYTE_W-1:0] s1_acc;
    logic              s1_emit;
    logic              s1_go;
    logic              out_free;

    logic              m_tvalid_reg;
    logic [BYTE_W-1:0] page_byte_reg;
    logic [COL_W-1:0]  column_index_reg;
    logic [PAGE_W-1:0] page_index_reg;
    logic              image_done_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_go    = s1_valid_reg && (!s1_emit || out_free);
    assign s_tready = !s1_valid_reg || s1_go;
    assign accept   = s_tvalid && s_tready;

    vpp_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .pos       (pos),
        .slot      (slot)
    );

    vpp_colbuf #(
        .DEPTH   (MAX_WIDTH),
        .AW      (AW)
    ) u_colbuf (
        .clk     (clk),
        .wr_en   (s1_go),
        .wr_addr (s1_slot_reg),
        .wr_data (s1_acc),
        .rd_en   (accept),
        .rd_addr (slot),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_lit_reg  <= (s_tdata != '0);
            s1_pos_reg  <= pos;
            s1_slot_reg <= slot;
        end
    end

    // the first row of a page starts the column byte fresh
    assign s1_sub  = s1_pos_reg.row[SUB_W-1:0];
    assign s1_bit  = BYTE_W'(s1_lit_reg) << s1_sub;
    assign s1_acc  = (s1_sub == '0) ? s1_bit : (rd_data | s1_bit);
    assign s1_emit = (s1_sub == SUB_W'(PAGE_ROWS - 1)) || s1_pos_reg.last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_tvalid_reg <= s1_go && s1_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_go && s1_emit)
        begin
            page_byte_reg    <= s1_acc;
            column_index_reg <= s1_pos_reg.col;
            page_index_reg   <= s1_pos_reg.row[ROW_W-1:SUB_W];
            image_done_reg   <= s1_pos_reg.last_row && s1_pos_reg.last_col;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, page_index_reg, column_index_reg, page_byte_reg};
    assign m_tlast  = image_done_reg;

endmodule

// ===== rtl/vpp_checker.sv =====
module vpp_protocol_checker
    import vpp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    // a held output word keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // input stalls only behind a full, stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // input back-pressure cannot appear unless a word was taken the cycle before
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("input ready dropped with no words in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:21] == '0)
        else $error("padding bits of output word not zero");

endmodule

bind bitmap_vertical_page_packer vpp_protocol_checker u_vpp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
